>>> rtl/lmb_pkg.sv
// Package: types, constants and state codes for the linear motion blur block.
package lmb_pkg;

  localparam int IMAGE_WIDTH_D  = 256;
  localparam int IMAGE_HEIGHT_D = 256;
  localparam int CHANNELS_D     = 4;
  localparam int MAX_LENGTH_D   = 256;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_DX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_DY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_LEFT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_TOP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_RIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_BOTTOM = 3'd6;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_BLUR  = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] chan0_in;
    logic [7:0] chan1_in;
    logic [7:0] chan2_in;
    logic [7:0] chan3_in;
  } in_req_t;

  typedef struct packed {
    logic [7:0] chan0_out;
    logic [7:0] chan1_out;
    logic [7:0] chan2_out;
    logic [7:0] chan3_out;
    logic [8:0] samples_used;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRC,
    ST_WALK,
    ST_DRAIN,
    ST_DIV,
    ST_OUT
  } lmb_state_t;

  // Lane control from the sequencer.
  typedef struct packed {
    logic clear;
    logic accum;
    logic div_start;
    logic div_step;
  } lmb_lane_ctl_t;

endpackage

>>> rtl/lmb_lane.sv
// One channel lane: sample accumulator and restoring serial divider.
module lmb_lane #(
  parameter int SUM_W = 16,
  parameter int CNT_W = 9
) (
  input  logic                    clk,
  input  lmb_pkg::lmb_lane_ctl_t  ctl,
  input  logic [7:0]              sample,
  input  logic [CNT_W-1:0]        divisor,
  output logic [7:0]              quotient
);

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0] rem_r, rem_nxt;
  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [SUM_W:0]   trial;

  // one quotient bit per cycle
  always_comb begin
    trial   = {rem_r[SUM_W-1:0], quo_r[SUM_W-1]} - {{(SUM_W+1-CNT_W){1'b0}}, divisor};
    sum_nxt = sum_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (ctl.clear) begin
      sum_nxt = '0;
    end else if (ctl.accum) begin
      sum_nxt = sum_r + {{(SUM_W-8){1'b0}}, sample};
    end
    if (ctl.div_start) begin
      rem_nxt = '0;
      quo_nxt = sum_nxt;
    end else if (ctl.div_step) begin
      if (!trial[SUM_W]) begin
        rem_nxt = trial[SUM_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[SUM_W-2:0], quo_r[SUM_W-1]};
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r[7:0];

endmodule

>>> rtl/linear_motion_blur_bresenham.sv
// Top level: pixel store, Bresenham walk sequencer, channel lanes and result merge.
//
//   channel | direction | handshake           | payload
//   in_     | in        | in_valid/in_stall   | in_data  (lmb_pkg::in_req_t)
//   out_    | out       | out_valid/out_stall | out_data (lmb_pkg::out_req_t)
//   cfg_    | in        | cfg_we              | cfg_idx, cfg_wdata
//
// A write request is written to the store as it is accepted. A blur request reads its
// samples through the single store read port (one sample a cycle; none when the source
// pixel is returned), then runs the one-bit-a-cycle divider in each lane; out_stall can
// hold the result further.
// Reset clears control state and configuration registers; the store itself is not cleared.
// in_stall is high while a blur request is in work or its result is unread.
module linear_motion_blur_bresenham #(
  parameter int IMAGE_WIDTH  = lmb_pkg::IMAGE_WIDTH_D,
  parameter int IMAGE_HEIGHT = lmb_pkg::IMAGE_HEIGHT_D,
  parameter int CHANNELS     = lmb_pkg::CHANNELS_D,
  parameter int MAX_LENGTH   = lmb_pkg::MAX_LENGTH_D
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lmb_pkg::in_req_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lmb_pkg::out_req_t                   out_data,
  input  logic                                cfg_we,
  input  logic [lmb_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [lmb_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int AW    = $clog2(IMAGE_WIDTH * IMAGE_HEIGHT);
  localparam int CW    = 14;   // walk coordinates, signed
  localparam int EW    = 13;   // error term, signed
  localparam int CNT_W = 9;
  localparam int SUM_W = CNT_W + 8;

  function automatic logic [AW-1:0] pix_addr(logic [CW-1:0] x, logic [CW-1:0] y);
    return AW'(32'(y) * 32'(IMAGE_WIDTH) + 32'(x));
  endfunction

  // ---------------- configuration ----------------
  logic [8:0] length_r, sel_right_r, sel_bottom_r;
  logic [9:0] end_dx_r, end_dy_r;
  logic [7:0] sel_left_r, sel_top_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r     <= 9'd5;
      end_dx_r     <= 10'd3;
      end_dy_r     <= 10'd3;
      sel_left_r   <= 8'd0;
      sel_top_r    <= 8'd0;
      sel_right_r  <= 9'd256;
      sel_bottom_r <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_idx)
        lmb_pkg::REG_LENGTH:     length_r     <= cfg_wdata[8:0];
        lmb_pkg::REG_END_DX:     end_dx_r     <= cfg_wdata[9:0];
        lmb_pkg::REG_END_DY:     end_dy_r     <= cfg_wdata[9:0];
        lmb_pkg::REG_SEL_LEFT:   sel_left_r   <= cfg_wdata[7:0];
        lmb_pkg::REG_SEL_TOP:    sel_top_r    <= cfg_wdata[7:0];
        lmb_pkg::REG_SEL_RIGHT:  sel_right_r  <= cfg_wdata[8:0];
        lmb_pkg::REG_SEL_BOTTOM: sel_bottom_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // derived selection and walk setup
  logic signed [CW-1:0] left_s, top_s, right_s, bottom_s;
  logic signed [CW-1:0] ox, oy;
  logic [CW-1:0] adx, ady;
  logic          steep;
  logic [8:0]    n_sat;

  always_comb begin
    left_s   = CW'(sel_left_r);
    top_s    = CW'(sel_top_r);
    right_s  = (CW'(sel_right_r) > CW'(IMAGE_WIDTH)) ? CW'(IMAGE_WIDTH) : CW'(sel_right_r);
    bottom_s = (CW'(sel_bottom_r) > CW'(IMAGE_HEIGHT)) ? CW'(IMAGE_HEIGHT)
                                                        : CW'(sel_bottom_r);
    ox    = CW'($signed(end_dx_r));
    oy    = CW'($signed(end_dy_r));
    adx   = ox[CW-1] ? -ox : ox;
    ady   = oy[CW-1] ? -oy : oy;
    steep = ady > adx;
    n_sat = (32'(length_r) > MAX_LENGTH) ? 9'(MAX_LENGTH) : length_r;
  end

  // ---------------- pixel store ----------------
  logic [31:0] mem [0:IMAGE_WIDTH*IMAGE_HEIGHT-1];
  logic [AW-1:0] rd_addr;
  logic          rd_ok, rd_ok_r;
  logic [31:0]   rd_q_r;
  logic          wr_en;
  logic [31:0]   wr_word, cmask;

  assign cmask = (CHANNELS >= 4) ? 32'hFFFF_FFFF : 32'((64'd1 << (8 * CHANNELS)) - 64'd1);
  assign wr_word = {in_data.chan3_in, in_data.chan2_in, in_data.chan1_in, in_data.chan0_in}
                   & cmask;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pix_addr(CW'(in_data.pos_x), CW'(in_data.pos_y))] <= wr_word;
    end
    rd_q_r  <= mem[rd_addr];
    rd_ok_r <= rd_ok;
  end

  // ---------------- sequencer ----------------
  lmb_pkg::lmb_state_t state_r, state_nxt;
  logic signed [CW-1:0] xx_r, yy_r, xx_nxt, yy_nxt;
  logic signed [EW-1:0] e_r, e_nxt, ddx_r, ddy_r;
  logic signed [1:0]    s1_r, s2_r;
  logic                 steep_r;
  logic [8:0]           n_r, i_r, i_nxt;
  logic [5:0]           dcnt_r, dcnt_nxt;
  logic                 mode_src_r;   // result is the source pixel
  logic [8:0]           used_r;
  lmb_pkg::lmb_lane_ctl_t ctl;
  logic                 acc_pend_r;
  logic                 acc_now;
  logic                 src_x_ok, src_y_ok, in_sel;
  logic signed [CW-1:0] px, py;
  logic                 leave;

  assign px = CW'(in_data.pos_x);
  assign py = CW'(in_data.pos_y);
  assign src_x_ok = (32'(in_data.pos_x) < IMAGE_WIDTH);
  assign src_y_ok = (32'(in_data.pos_y) < IMAGE_HEIGHT);
  assign in_sel   = px >= left_s && px < right_s && py >= top_s && py < bottom_s;

  logic accept;
  assign accept = in_valid && !in_stall;
  assign wr_en  = accept && in_data.opcode == lmb_pkg::OP_WRITE && src_x_ok && src_y_ok;

  // Bresenham step
  always_comb begin
    xx_nxt = xx_r;
    yy_nxt = yy_r;
    e_nxt  = e_r;
    if (!e_r[EW-1]) begin
      if (steep_r) xx_nxt = xx_r + CW'(s1_r);
      else         yy_nxt = yy_r + CW'(s2_r);
      e_nxt = e_r - ddx_r;
    end
    if (steep_r) yy_nxt = yy_nxt + CW'(s2_r);
    else         xx_nxt = xx_nxt + CW'(s1_r);
    e_nxt = e_nxt + ddy_r;
    leave = xx_nxt < left_s || xx_nxt >= right_s || yy_nxt < top_s || yy_nxt >= bottom_s;
    i_nxt = i_r + 9'd1;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lmb_pkg::ST_IDLE:
        if (accept && in_data.opcode == lmb_pkg::OP_BLUR) state_nxt = lmb_pkg::ST_SRC;
      lmb_pkg::ST_SRC:
        state_nxt = mode_src_r ? lmb_pkg::ST_DRAIN : lmb_pkg::ST_WALK;
      lmb_pkg::ST_WALK:
        if (i_nxt == n_r || leave) state_nxt = lmb_pkg::ST_DRAIN;
      lmb_pkg::ST_DRAIN:
        state_nxt = lmb_pkg::ST_DIV;
      lmb_pkg::ST_DIV:
        if (dcnt_r == 6'(SUM_W - 1)) state_nxt = lmb_pkg::ST_OUT;
      lmb_pkg::ST_OUT:
        if (!out_stall) state_nxt = lmb_pkg::ST_IDLE;
      default: state_nxt = lmb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = state_r != lmb_pkg::ST_IDLE;
    out_valid = state_r == lmb_pkg::ST_OUT;
    rd_ok     = 1'b1;
    rd_addr   = pix_addr(xx_r, yy_r);
    if (state_r == lmb_pkg::ST_IDLE) begin
      rd_addr = pix_addr(px, py);
      rd_ok   = src_x_ok && src_y_ok;
    end else if (state_r != lmb_pkg::ST_WALK) begin
      rd_ok   = 1'b0;
    end
    acc_now       = state_r == lmb_pkg::ST_WALK;
    ctl.clear     = state_r == lmb_pkg::ST_SRC;
    ctl.accum     = acc_pend_r;
    ctl.div_start = state_r == lmb_pkg::ST_DRAIN;
    ctl.div_step  = state_r == lmb_pkg::ST_DIV;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lmb_pkg::ST_IDLE;
      acc_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      acc_pend_r <= acc_now;
    end
  end

  // source-pixel capture and walk registers
  logic [31:0] src_pix_r;
  logic [CW-1:0] wdx, wdy;

  always_comb begin
    dcnt_nxt = (state_r == lmb_pkg::ST_DIV) ? dcnt_r + 6'd1 : 6'd0;
    wdx = steep ? ady : adx;
    wdy = steep ? adx : ady;
  end

  always_ff @(posedge clk) begin
    dcnt_r <= dcnt_nxt;
    if (state_r == lmb_pkg::ST_IDLE && accept) begin
      xx_r    <= px;
      yy_r    <= py;
      i_r     <= 9'd0;
      n_r     <= n_sat;
      steep_r <= steep;
      s1_r    <= ox[CW-1] ? 2'sb11 : (ox == 0 ? 2'sb00 : 2'sb01);
      s2_r    <= oy[CW-1] ? 2'sb11 : (oy == 0 ? 2'sb00 : 2'sb01);
      ddx_r   <= EW'(wdx << 1);
      ddy_r   <= EW'(wdy << 1);
      e_r     <= EW'(wdy << 1) - EW'(wdx);
      mode_src_r <= !in_sel || n_sat == 9'd0 || (ox == 0 && oy == 0);
      used_r  <= (!in_sel || n_sat == 9'd0) ? 9'd0 : n_sat;
    end
    if (state_r == lmb_pkg::ST_SRC) begin
      src_pix_r <= rd_ok_r ? (rd_q_r & cmask) : 32'd0;
    end
    if (state_r == lmb_pkg::ST_WALK) begin
      xx_r <= xx_nxt;
      yy_r <= yy_nxt;
      e_r  <= e_nxt;
      i_r  <= i_nxt;
    end
    if (state_r == lmb_pkg::ST_DRAIN && !mode_src_r) begin
      used_r <= i_r;
    end
  end

  // ---------------- lanes ----------------
  logic [31:0] sample_w;
  logic [7:0]  q [0:3];
  assign sample_w = rd_q_r & cmask;

  for (genvar c = 0; c < 4; c++) begin : g_lane
    lmb_lane #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_lane (
      .clk     (clk),
      .ctl     (ctl),
      .sample  (sample_w[8*c +: 8]),
      .divisor (i_r),
      .quotient(q[c])
    );
  end

  // ---------------- merge ----------------
  logic [31:0] res_pix;
  assign res_pix = mode_src_r ? src_pix_r : ({q[3], q[2], q[1], q[0]} & cmask);

  assign out_data.chan0_out    = res_pix[7:0];
  assign out_data.chan1_out    = res_pix[15:8];
  assign out_data.chan2_out    = res_pix[23:16];
  assign out_data.chan3_out    = res_pix[31:24];
  assign out_data.samples_used = used_r;

endmodule

>>> rtl/lmb_checker.sv
// Port checker for the linear motion blur block, bound to the top level.
module lmb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input lmb_pkg::in_req_t   in_data,
  input logic               out_valid,
  input logic               out_stall,
  input lmb_pkg::out_req_t  out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy_with_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request taken while result pending");

  a_blur_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.opcode == lmb_pkg::OP_BLUR |=> in_stall)
    else $error("blur request did not occupy the block");

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.samples_used <= 9'd256)
    else $error("sample count out of range");

endmodule

bind linear_motion_blur_bresenham lmb_checker u_lmb_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

>>> tb/sv/tb.sv
// Testbench for linear_motion_blur_bresenham: directed and random writes and blur requests vs. a predictor.
`timescale 1ns / 100ps
module tb;

  class blur_scoreboard;
    bit [31:0] image [int];
    int unsigned blur_len;
    int sx, sy, sleft, stop, sright, sbottom;
    lmb_pkg::out_req_t pending [$];
    int errors;

    function new();
      errors = 0;
      blur_len = 5; sx = 3; sy = 3;
      sleft = 0; stop = 0; sright = 256; sbottom = 256;
    endfunction

    function void set_reg(logic [lmb_pkg::CFG_IDX_W-1:0] idx,
                          logic [lmb_pkg::CFG_DATA_W-1:0] v);
      case (idx)
        lmb_pkg::REG_LENGTH: blur_len = v[8:0];
        lmb_pkg::REG_END_DX: sx = $signed(v);
        lmb_pkg::REG_END_DY: sy = $signed(v);
        lmb_pkg::REG_SEL_LEFT: sleft = v[7:0];
        lmb_pkg::REG_SEL_TOP: stop = v[7:0];
        lmb_pkg::REG_SEL_RIGHT: sright = v[8:0];
        lmb_pkg::REG_SEL_BOTTOM: sbottom = v[8:0];
        default: ;
      endcase
    endfunction

    function bit [31:0] pix_at(int x, int y);
      if (x < 0 || y < 0 || x > 255 || y > 255 || !image.exists(y * 256 + x)) return 0;
      return image[y * 256 + x];
    endfunction

    function void note_request(lmb_pkg::in_req_t r);
      int x, y, r_, b_, n, dx, dy, s1, s2, e, t, xx, yy;
      bit steep, in_sel;
      int unsigned sum [4];
      int unsigned cnt;
      bit [31:0] p, res;
      lmb_pkg::out_req_t o;
      x = r.pos_x; y = r.pos_y;
      if (r.opcode == lmb_pkg::OP_WRITE) begin
        image[y * 256 + x] = {r.chan3_in, r.chan2_in, r.chan1_in, r.chan0_in};
        return;
      end
      r_ = sright > 256 ? 256 : sright;
      b_ = sbottom > 256 ? 256 : sbottom;
      n = blur_len > 256 ? 256 : blur_len;
      in_sel = x >= sleft && x < r_ && y >= stop && y < b_;
      res = pix_at(x, y);
      cnt = 0;
      if (!in_sel || n == 0) cnt = 0;
      else if (sx == 0 && sy == 0) cnt = n;
      else begin
        dx = sx < 0 ? -sx : sx; dy = sy < 0 ? -sy : sy;
        s1 = sx > 0 ? 1 : (sx < 0 ? -1 : 0);
        s2 = sy > 0 ? 1 : (sy < 0 ? -1 : 0);
        steep = dy > dx;
        if (steep) begin t = dx; dx = dy; dy = t; end
        dy *= 2; e = dy - dx; dx *= 2;
        xx = x; yy = y;
        for (int c = 0; c < 4; c++) sum[c] = 0;
        while (cnt < n) begin
          p = pix_at(xx, yy);
          for (int c = 0; c < 4; c++) sum[c] += p[8*c +: 8];
          cnt++;
          if (e >= 0) begin
            if (steep) xx += s1; else yy += s2;
            e -= dx;
          end
          if (steep) yy += s2; else xx += s1;
          e += dy;
          if (xx < sleft || xx >= r_ || yy < stop || yy >= b_) break;
        end
        for (int c = 0; c < 4; c++) res[8*c +: 8] = sum[c] / cnt;
      end
      o.chan0_out = res[7:0]; o.chan1_out = res[15:8];
      o.chan2_out = res[23:16]; o.chan3_out = res[31:24];
      o.samples_used = cnt[8:0];
      pending.push_back(o);
    endfunction

    function void check_result(lmb_pkg::out_req_t a);
      lmb_pkg::out_req_t x;
      if (pending.size() == 0) begin
        $error("unexpected result %h", a); errors++; return;
      end
      x = pending.pop_front();
      if (a.chan0_out !== x.chan0_out) begin
        $error("chan0_out exp %0d got %0d", x.chan0_out, a.chan0_out); errors++;
      end
      if (a.chan1_out !== x.chan1_out) begin
        $error("chan1_out exp %0d got %0d", x.chan1_out, a.chan1_out); errors++;
      end
      if (a.chan2_out !== x.chan2_out) begin
        $error("chan2_out exp %0d got %0d", x.chan2_out, a.chan2_out); errors++;
      end
      if (a.chan3_out !== x.chan3_out) begin
        $error("chan3_out exp %0d got %0d", x.chan3_out, a.chan3_out); errors++;
      end
      if (a.samples_used !== x.samples_used) begin
        $error("samples_used exp %0d got %0d", x.samples_used, a.samples_used); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall, cfg_we;
  lmb_pkg::in_req_t in_data;
  lmb_pkg::out_req_t out_data;
  logic [lmb_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [lmb_pkg::CFG_DATA_W-1:0] cfg_wdata;
  blur_scoreboard sb;
  bit done_driving;
  int idle_cycles = 0;
  bit written [65536];
  int wlist [$];

  linear_motion_blur_bresenham u_top (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0) ? 1'b1 : ($urandom_range(0, 60) == 0);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send(lmb_pkg::in_req_t r);
    int g;
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
    if (r.opcode == lmb_pkg::OP_WRITE) begin
      if (!written[{r.pos_y, r.pos_x}]) wlist.push_back({r.pos_y, r.pos_x});
      written[{r.pos_y, r.pos_x}] = 1;
    end
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic put_pixel(int x, int y);
    lmb_pkg::in_req_t r;
    r = '0;
    r.opcode = lmb_pkg::OP_WRITE; r.pos_x = 8'(x); r.pos_y = 8'(y);
    r.chan0_in = 8'($urandom); r.chan1_in = 8'($urandom); r.chan2_in = 8'($urandom);
    r.chan3_in = 8'($urandom);
    send(r);
  endtask

  task automatic blur_at(int x, int y);
    lmb_pkg::in_req_t r;
    r = '0;
    r.opcode = lmb_pkg::OP_BLUR; r.pos_x = 8'(x); r.pos_y = 8'(y);
    send(r);
  endtask

  // Every store read of a blur must hit a written pixel: check the path first.
  function automatic bit path_ok(int x, int y);
    int r_, b_, n, dx, dy, s1, s2, e, t, xx, yy, cnt;
    bit steep;
    if (!written[y * 256 + x]) return 0;
    r_ = sb.sright > 256 ? 256 : sb.sright;
    b_ = sb.sbottom > 256 ? 256 : sb.sbottom;
    n = sb.blur_len > 256 ? 256 : sb.blur_len;
    if (!(x >= sb.sleft && x < r_ && y >= sb.stop && y < b_) || n == 0) return 1;
    if (sb.sx == 0 && sb.sy == 0) return 1;
    dx = sb.sx < 0 ? -sb.sx : sb.sx; dy = sb.sy < 0 ? -sb.sy : sb.sy;
    s1 = sb.sx > 0 ? 1 : (sb.sx < 0 ? -1 : 0);
    s2 = sb.sy > 0 ? 1 : (sb.sy < 0 ? -1 : 0);
    steep = dy > dx;
    if (steep) begin t = dx; dx = dy; dy = t; end
    dy *= 2; e = dy - dx; dx *= 2;
    xx = x; yy = y; cnt = 0;
    while (cnt < n) begin
      if (!written[yy * 256 + xx]) return 0;
      cnt++;
      if (e >= 0) begin
        if (steep) xx += s1; else yy += s2;
        e -= dx;
      end
      if (steep) yy += s2; else xx += s1;
      e += dy;
      if (xx < sb.sleft || xx >= r_ || yy < sb.stop || yy >= b_) break;
    end
    return 1;
  endfunction

  task automatic try_blur(int x, int y);
    if (path_ok(x, y)) blur_at(x, y);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_reg(logic [lmb_pkg::CFG_IDX_W-1:0] idx, int v);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= v[lmb_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    sb.set_reg(idx, v[lmb_pkg::CFG_DATA_W-1:0]);
  endtask

  task automatic setup(int len, int dx, int dy, int l, int t, int r, int b);
    wait_drain();
    set_reg(lmb_pkg::REG_LENGTH, len);
    set_reg(lmb_pkg::REG_END_DX, dx); set_reg(lmb_pkg::REG_END_DY, dy);
    set_reg(lmb_pkg::REG_SEL_LEFT, l); set_reg(lmb_pkg::REG_SEL_TOP, t);
    set_reg(lmb_pkg::REG_SEL_RIGHT, r); set_reg(lmb_pkg::REG_SEL_BOTTOM, b);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int k, x, y;
    sb = new();
    rst_n = 0; in_valid = 0; in_data = '0; cfg_we = 0; cfg_idx = '0; cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // fill a band of rows fully and the corners
    for (int yy = 0; yy < 4; yy++)
      for (int xx = 0; xx < 256; xx++) put_pixel(xx, yy);
    put_pixel(255, 255); put_pixel(0, 255); put_pixel(255, 0);
    // directed: reset setting, extremes, zero length, zero offset, clipping
    try_blur(0, 0); try_blur(255, 0); try_blur(255, 255);
    setup(0, 3, 3, 0, 0, 256, 256); try_blur(10, 2);
    setup(256, 0, 0, 0, 0, 256, 256); try_blur(0, 255); try_blur(7, 3);
    setup(511, 256, 0, 0, 0, 511, 511); try_blur(0, 3);
    setup(256, -256, 0, 0, 0, 256, 256); try_blur(255, 2);
    setup(300, 1, 0, 0, 0, 256, 4); try_blur(0, 0);
    setup(20, 5, -1, 0, 0, 256, 4); try_blur(3, 3); try_blur(100, 0);
    setup(9, -2, 511, 0, 0, 256, 4); try_blur(50, 0); try_blur(50, 3);
    setup(9, 3, 3, 200, 4, 100, 2); try_blur(255, 255); try_blur(210, 2);
    setup(9, 3, 3, 255, 255, 256, 256); try_blur(255, 255); try_blur(0, 0);
    setup(5, 3, 3, 0, 0, 256, 256);
    for (int ph = 0; ph < 8; ph++) begin
      k = $urandom_range(0, 9);
      setup(k < 2 ? $urandom_range(250, 511) : $urandom_range(0, 40),
            $signed($urandom_range(0, 80)) - 40, $signed($urandom_range(0, 16)) - 8,
            $urandom_range(0, 30), $urandom_range(0, 2),
            $urandom_range(100, 511), $urandom_range(3, 300));
      for (int i = 0; i < 110; i++) begin
        if ($urandom_range(0, 2) == 0) begin
          x = $urandom_range(0, 255); y = $urandom_range(0, 255);
          put_pixel(x, y);
        end else if ($urandom_range(0, 3) == 0) begin
          k = wlist[$urandom_range(0, wlist.size() - 1)];
          try_blur(k % 256, k / 256);
        end else
          try_blur($urandom_range(0, 255), $urandom_range(0, 3));
      end
    end
    wait_drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
